/* rtl/fts_pkg.sv */
// package: shared constants and register codes for the follow-target speed law
package fts_pkg;

  localparam int SAMPLE_COUNT = 5;
  localparam int DEPTH_BITS   = 16;
  localparam int CNT_W        = $clog2(SAMPLE_COUNT + 1);
  localparam int POS_W        = 12;
  localparam int CX_W         = POS_W + 1;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int SPEED_W      = 9;
  localparam int TURN_W       = 11;
  localparam int MEAN_W       = 16;
  localparam int STOP_W       = 8;

  // speed law constants
  localparam int SPEED_MIN_MEAN  = 1000;
  localparam int SPEED_SAT_MEAN  = 5000;  // mean*3/40+25 reaches the cap here
  localparam int SPEED_OFFSET    = 25;
  localparam int SPEED_CAP       = 400;
  localparam int DIV5_RECIP      = 52429; // 2^18/5 rounded up
  localparam int DIV5_SHIFT      = 18;

  // turn law constants
  localparam int TURN_FULL       = 750;
  localparam int TURN_LEFT_BASE  = 1200;
  localparam int TURN_RIGHT_BASE = 1360;
  localparam int TURN_MAX        = 1023;
  localparam int TURN_MIN        = -1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DEPTH   = 3'd0,
    REG_MAX_DEPTH   = 3'd1,
    REG_LEFT_OUTER  = 3'd2,
    REG_LEFT_INNER  = 3'd3,
    REG_RIGHT_INNER = 3'd4,
    REG_RIGHT_OUTER = 3'd5,
    REG_STOP_LIMIT  = 3'd6
  } cfg_reg_t;

endpackage

/* rtl/fts_in_if.sv */
// interface: input channel carrying one depth frame transaction
interface fts_in_if #(
  parameter int DEPTH_BITS = fts_pkg::DEPTH_BITS
);
  logic                          valid;
  logic                          ready;
  logic [DEPTH_BITS-1:0]         depth_upper_left;
  logic [DEPTH_BITS-1:0]         depth_upper_right;
  logic [DEPTH_BITS-1:0]         depth_lower_left;
  logic [DEPTH_BITS-1:0]         depth_lower_right;
  logic [DEPTH_BITS-1:0]         depth_middle;
  logic [fts_pkg::POS_W-1:0]     box_left;
  logic [fts_pkg::POS_W-1:0]     box_span;
  logic                          object_mode;

  modport source (
    output valid, depth_upper_left, depth_upper_right, depth_lower_left,
           depth_lower_right, depth_middle, box_left, box_span, object_mode,
    input  ready
  );
  modport sink (
    input  valid, depth_upper_left, depth_upper_right, depth_lower_left,
           depth_lower_right, depth_middle, box_left, box_span, object_mode,
    output ready
  );
endinterface

/* rtl/fts_out_if.sv */
// interface: result channel carrying one speed command transaction
interface fts_out_if;
  logic                                valid;
  logic                                ready;
  logic [fts_pkg::SPEED_W-1:0]         forward_speed;
  logic signed [fts_pkg::TURN_W-1:0]   turn_rate;
  logic [fts_pkg::MEAN_W-1:0]          mean_depth;
  logic [fts_pkg::CNT_W-1:0]           valid_points;
  logic                                finished;

  modport source (
    output valid, forward_speed, turn_rate, mean_depth, valid_points, finished,
    input  ready
  );
  modport sink (
    input  valid, forward_speed, turn_rate, mean_depth, valid_points, finished,
    output ready
  );
endinterface

/* rtl/fts_lane.sv */
// module: one sample lane, window check and masking of a depth sample
module fts_lane #(
  parameter int DEPTH_BITS = fts_pkg::DEPTH_BITS
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic [DEPTH_BITS-1:0] sample,
  input  logic [15:0]           min_depth,
  input  logic [15:0]           max_depth,
  output logic [DEPTH_BITS-1:0] kept_r,
  output logic                  ok_r
);

  logic [32:0] sample_x;
  logic        in_window;

  assign sample_x  = 33'(sample);
  assign in_window = (sample_x > 33'(min_depth)) && (sample_x < 33'(max_depth));

  always_ff @(posedge clk) begin
    if (load) begin
      ok_r   <= in_window;
      kept_r <= in_window ? sample : '0;
    end
  end

endmodule

/* rtl/fts_merge.sv */
// module: merging stage, sum and count of the lane results
module fts_merge #(
  parameter int DEPTH_BITS = fts_pkg::DEPTH_BITS,
  parameter int LANES      = fts_pkg::SAMPLE_COUNT,
  parameter int SUM_W      = DEPTH_BITS + $clog2(LANES),
  parameter int CNT_W      = $clog2(LANES + 1)
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic [DEPTH_BITS-1:0] kept [LANES],
  input  logic [LANES-1:0]      ok,
  output logic [SUM_W-1:0]      sum_r,
  output logic [CNT_W-1:0]      count_r
);

  logic [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0] count_nxt;

  always_comb begin
    sum_nxt   = '0;
    count_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_nxt   = sum_nxt + SUM_W'(kept[i]);
      count_nxt = count_nxt + CNT_W'(ok[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* rtl/fts_div.sv */
// module: restoring divider, one quotient bit per cycle
module fts_div #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done_r,
  output logic [NUM_W-1:0] quot_r
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] steps_r;
  logic              busy_r;
  logic [DEN_W:0]    rem_sh;
  logic              fits;
  logic [DEN_W:0]    rem_diff;

  assign rem_sh   = {rem_r, quot_r[NUM_W-1]};
  assign fits     = rem_sh >= {1'b0, den_r};
  assign rem_diff = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      steps_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        steps_r <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        steps_r <= steps_r - 1'b1;
        if (steps_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= num;
      den_r  <= den;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quot_r <= {quot_r[NUM_W-2:0], fits};
    end
  end

endmodule

/* rtl/follow_target_speed_law.sv */
// top level: follow-target speed law, depth lanes, mean divider and speed/turn laws
//
//  channel  | direction | payload                                        | handshake
//  ---------+-----------+------------------------------------------------+-----------
//  in_ch    | in        | five depth samples, box_left, box_span, mode   | valid/ready
//  out_ch   | out       | forward_speed, turn_rate, mean_depth, count,   | valid/ready
//           |           | finished                                       |
//  cfg_*    | in        | register index and write data                  | write enable
//
//  one transaction at a time: an accepted frame passes the lane registers, the
//  merge registers, the restoring divider that yields one mean bit a cycle, the
//  scale registers and the output register; no valid sample skips the divider
//  rst_n is synchronous and active low; it restores the register defaults and
//  clears the zero-speed run counter
//  the result sits in an output register, so a stalled sink only holds the
//  block once the next result is ready and the output is still occupied
module follow_target_speed_law #(
  parameter int DEPTH_BITS = fts_pkg::DEPTH_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fts_in_if.sink                          in_ch,
  fts_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [fts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int LANES  = fts_pkg::SAMPLE_COUNT;
  localparam int CNT_W  = fts_pkg::CNT_W;
  localparam int SUM_W  = DEPTH_BITS + $clog2(LANES);
  localparam int POS_W  = fts_pkg::POS_W;
  localparam int CX_W   = fts_pkg::CX_W;
  localparam int STOP_W = fts_pkg::STOP_W;
  localparam int Y_W    = 11;               // floor(mean*3/8) below the cap
  localparam int PROD_W = Y_W + 17;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_START,
    ST_DIV,
    ST_SCALE,
    ST_FINAL
  } state_t;

  // configuration registers
  logic [15:0]        min_depth_r;
  logic [15:0]        max_depth_r;
  logic [POS_W-1:0]   left_outer_r;
  logic [POS_W-1:0]   left_inner_r;
  logic [POS_W-1:0]   right_inner_r;
  logic [POS_W-1:0]   right_outer_r;
  logic [STOP_W-1:0]  stop_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_depth_r   <= 16'd400;
      max_depth_r   <= 16'd8000;
      left_outer_r  <= 12'd200;
      left_inner_r  <= 12'd600;
      right_inner_r <= 12'd680;
      right_outer_r <= 12'd1080;
      stop_limit_r  <= 8'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fts_pkg::REG_MIN_DEPTH:   min_depth_r   <= cfg_wdata;
        fts_pkg::REG_MAX_DEPTH:   max_depth_r   <= cfg_wdata;
        fts_pkg::REG_LEFT_OUTER:  left_outer_r  <= cfg_wdata[POS_W-1:0];
        fts_pkg::REG_LEFT_INNER:  left_inner_r  <= cfg_wdata[POS_W-1:0];
        fts_pkg::REG_RIGHT_INNER: right_inner_r <= cfg_wdata[POS_W-1:0];
        fts_pkg::REG_RIGHT_OUTER: right_outer_r <= cfg_wdata[POS_W-1:0];
        fts_pkg::REG_STOP_LIMIT:  stop_limit_r  <= cfg_wdata[STOP_W-1:0];
        default: ;
      endcase
    end
  end

  state_t state_r;
  logic   in_fire;
  logic   out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;

  // sample lanes
  logic [DEPTH_BITS-1:0] samples [LANES];
  logic [DEPTH_BITS-1:0] kept    [LANES];
  logic [LANES-1:0]      ok;

  assign samples[0] = in_ch.depth_upper_left;
  assign samples[1] = in_ch.depth_upper_right;
  assign samples[2] = in_ch.depth_lower_left;
  assign samples[3] = in_ch.depth_lower_right;
  assign samples[4] = in_ch.depth_middle;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    fts_lane #(.DEPTH_BITS(DEPTH_BITS)) u_lane (
      .clk       (clk),
      .load      (in_fire),
      .sample    (samples[g]),
      .min_depth (min_depth_r),
      .max_depth (max_depth_r),
      .kept_r    (kept[g]),
      .ok_r      (ok[g])
    );
  end

  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] count;

  fts_merge #(
    .DEPTH_BITS (DEPTH_BITS),
    .LANES      (LANES),
    .SUM_W      (SUM_W),
    .CNT_W      (CNT_W)
  ) u_merge (
    .clk     (clk),
    .load    (state_r == ST_MERGE),
    .kept    (kept),
    .ok      (ok),
    .sum_r   (sum),
    .count_r (count)
  );

  // mean = sum / count, skipped when nothing was valid
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] quot;

  assign div_start = (state_r == ST_START) && (count != '0);

  fts_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (sum),
    .den    (count),
    .done_r (div_done),
    .quot_r (quot)
  );

  // item side registers
  logic [CX_W-1:0] cx_r;
  logic            obj_r;
  logic [32:0]     mean_r;

  // speed law: below the cap, floor(mean*3/40) = floor(floor(mean*3/8)/5)
  logic [Y_W-1:0]    y_div8;
  logic [PROD_W-1:0] prod_r;
  logic              above_min_r;
  logic              at_cap_r;
  logic [14:0]       mean_x3;

  assign mean_x3 = {2'b00, mean_r[12:0]} + {1'b0, mean_r[12:0], 1'b0};
  assign y_div8  = mean_x3[13:3];

  // turn law over the box center, strict bounds on every band
  logic signed [15:0]  cx_s;
  logic signed [15:0]  band_val;
  logic signed [15:0]  turn_wide;
  logic signed [10:0]  turn_r;
  logic [CX_W-1:0]     lo1, lo2, ri1, ri2;

  assign lo1  = CX_W'(left_outer_r);
  assign lo2  = CX_W'(left_inner_r);
  assign ri1  = CX_W'(right_inner_r);
  assign ri2  = CX_W'(right_outer_r);
  assign cx_s = signed'(16'(cx_r));

  always_comb begin
    if (cx_r < lo1) begin
      band_val = 16'(fts_pkg::TURN_FULL);
    end else if (cx_r > lo1 && cx_r < lo2) begin
      band_val = 16'(fts_pkg::TURN_LEFT_BASE) - (cx_s <<< 1);
    end else if (cx_r > ri1 && cx_r < ri2) begin
      band_val = 16'(fts_pkg::TURN_RIGHT_BASE) - (cx_s <<< 1);
    end else if (cx_r > ri2) begin
      band_val = -16'sd750;
    end else begin
      band_val = '0;
    end
    // saturate to the 11-bit signed range
    if (band_val > 16'sd1023) begin
      turn_wide = 16'(fts_pkg::TURN_MAX);
    end else if (band_val < -16'sd1024) begin
      turn_wide = 16'(fts_pkg::TURN_MIN);
    end else begin
      turn_wide = band_val;
    end
  end

  // final speed and stop counting
  logic [8:0]        speed_raw;
  logic [PROD_W-1:0] prod_q;
  logic [STOP_W-1:0] run_r;
  logic [STOP_W-1:0] run_step;
  logic              run_over;

  assign prod_q = prod_r >> fts_pkg::DIV5_SHIFT;

  always_comb begin
    if (at_cap_r) begin
      speed_raw = 9'(fts_pkg::SPEED_CAP);
    end else if (above_min_r) begin
      speed_raw = prod_q[8:0] + 9'(fts_pkg::SPEED_OFFSET);
    end else begin
      speed_raw = '0;
    end
  end

  always_comb begin
    if (speed_raw == '0 && turn_r == '0) begin
      run_step = (run_r == '1) ? run_r : run_r + 1'b1;
    end else begin
      run_step = '0;
    end
    run_over = run_step > stop_limit_r;
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_ch.valid <= 1'b0;
      run_r        <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE:  if (in_fire) state_r <= ST_MERGE;
        ST_MERGE: state_r <= ST_START;
        ST_START: state_r <= (count != '0) ? ST_DIV : ST_SCALE;
        ST_DIV:   if (div_done) state_r <= ST_SCALE;
        ST_SCALE: state_r <= ST_FINAL;
        ST_FINAL: begin
          if (out_free) begin
            run_r   <= run_over ? '0 : run_step;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      // a new result takes the slot, otherwise an accepted one frees it
      if (state_r == ST_FINAL && out_free) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cx_r  <= CX_W'(in_ch.box_left) + CX_W'(in_ch.box_span >> 1);
      obj_r <= in_ch.object_mode;
    end
    if (state_r == ST_START && count == '0) begin
      mean_r <= '0;
    end else if (state_r == ST_DIV && div_done) begin
      mean_r <= 33'(quot);
    end
    if (state_r == ST_SCALE) begin
      prod_r      <= PROD_W'(y_div8) * PROD_W'(fts_pkg::DIV5_RECIP);
      above_min_r <= mean_r > 33'(fts_pkg::SPEED_MIN_MEAN);
      at_cap_r    <= mean_r >= 33'(fts_pkg::SPEED_SAT_MEAN);
      turn_r      <= turn_wide[10:0];
    end
    if (state_r == ST_FINAL && out_free) begin
      out_ch.forward_speed <= obj_r ? '0 : speed_raw;
      out_ch.turn_rate     <= turn_r;
      out_ch.mean_depth    <= mean_r[15:0];
      out_ch.valid_points  <= count;
      out_ch.finished      <= run_over;
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// testbench: directed and random checks of the follow-target speed law against a scoreboard
module testbench;

  localparam int DEPTH_BITS   = fts_pkg::DEPTH_BITS;
  localparam int SAMPLE_COUNT = fts_pkg::SAMPLE_COUNT;
  localparam int POS_W        = fts_pkg::POS_W;
  localparam int SPEED_W      = fts_pkg::SPEED_W;
  localparam int TURN_W       = fts_pkg::TURN_W;
  localparam int MEAN_W       = fts_pkg::MEAN_W;
  localparam int CNT_W        = fts_pkg::CNT_W;
  localparam int CFG_IDX_W    = fts_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = fts_pkg::CFG_DATA_W;
  localparam int STOP_W       = fts_pkg::STOP_W;

  // one depth frame as offered on the input channel
  typedef struct {
    logic [DEPTH_BITS-1:0] depth [SAMPLE_COUNT];
    logic [POS_W-1:0]      box_left;
    logic [POS_W-1:0]      box_span;
    logic                  object_mode;
  } frame_t;

  // one speed command as seen on the result channel
  typedef struct {
    logic [SPEED_W-1:0]       forward_speed;
    logic signed [TURN_W-1:0] turn_rate;
    logic [MEAN_W-1:0]        mean_depth;
    logic [CNT_W-1:0]         valid_points;
    logic                     finished;
  } command_t;

  // one full register setting
  typedef struct {
    logic [CFG_DATA_W-1:0] min_depth;
    logic [CFG_DATA_W-1:0] max_depth;
    logic [POS_W-1:0]      left_outer;
    logic [POS_W-1:0]      left_inner;
    logic [POS_W-1:0]      right_inner;
    logic [POS_W-1:0]      right_outer;
    logic [STOP_W-1:0]     stop_limit;
  } reg_set_t;

  // scoreboard: shadow registers, zero-speed run counter and queue of expected commands
  class speed_law_scoreboard;
    logic [DEPTH_BITS-1:0] min_depth;
    logic [DEPTH_BITS-1:0] max_depth;
    logic [POS_W-1:0]      left_outer;
    logic [POS_W-1:0]      left_inner;
    logic [POS_W-1:0]      right_inner;
    logic [POS_W-1:0]      right_outer;
    logic [STOP_W-1:0]     stop_limit;
    logic [STOP_W-1:0]     zero_run;
    command_t              expected_cmds[$];
    int                    failures;
    int                    results_seen;

    function new();
      min_depth    = 400;
      max_depth    = 8000;
      left_outer   = 200;
      left_inner   = 600;
      right_inner  = 680;
      right_outer  = 1080;
      stop_limit   = 20;
      zero_run     = '0;
      failures     = 0;
      results_seen = 0;
    endfunction

    function void set_reg(fts_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        fts_pkg::REG_MIN_DEPTH:   min_depth   = data;
        fts_pkg::REG_MAX_DEPTH:   max_depth   = data;
        fts_pkg::REG_LEFT_OUTER:  left_outer  = data[POS_W-1:0];
        fts_pkg::REG_LEFT_INNER:  left_inner  = data[POS_W-1:0];
        fts_pkg::REG_RIGHT_INNER: right_inner = data[POS_W-1:0];
        fts_pkg::REG_RIGHT_OUTER: right_outer = data[POS_W-1:0];
        fts_pkg::REG_STOP_LIMIT:  stop_limit  = data[STOP_W-1:0];
        default: ;
      endcase
    endfunction

    // five strict bands of the box center, then 11-bit saturation
    function int turn_for(int cx);
      int r;
      if (cx < int'(left_outer))
        r = fts_pkg::TURN_FULL;
      else if (cx > int'(left_outer) && cx < int'(left_inner))
        r = fts_pkg::TURN_LEFT_BASE - 2 * cx;
      else if (cx > int'(right_inner) && cx < int'(right_outer))
        r = fts_pkg::TURN_RIGHT_BASE - 2 * cx;
      else if (cx > int'(right_outer))
        r = -fts_pkg::TURN_FULL;
      else
        r = 0;
      if (r > fts_pkg::TURN_MAX) r = fts_pkg::TURN_MAX;
      if (r < fts_pkg::TURN_MIN) r = fts_pkg::TURN_MIN;
      return r;
    endfunction

    function command_t predict_command(frame_t f);
      command_t c;
      int sum;
      int count;
      int mean;
      int speed;
      int cx;
      int turn;
      sum   = 0;
      count = 0;
      mean  = 0;
      speed = 0;
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
        if (f.depth[i] > min_depth && f.depth[i] < max_depth) begin
          sum += int'(f.depth[i]);
          count++;
        end
      end
      if (count != 0) mean = sum / count;
      if (mean > fts_pkg::SPEED_MIN_MEAN) begin
        speed = mean * 3 / 40 + fts_pkg::SPEED_OFFSET;
        if (speed > fts_pkg::SPEED_CAP) speed = fts_pkg::SPEED_CAP;
      end
      cx   = int'(f.box_left) + int'(f.box_span) / 2;
      turn = turn_for(cx);
      // the run counter looks at the raw speed, before object mode
      if (speed == 0 && turn == 0) begin
        if (zero_run != '1) zero_run++;
      end else begin
        zero_run = '0;
      end
      c.finished = 1'b0;
      if (zero_run > stop_limit) begin
        c.finished = 1'b1;
        zero_run   = '0;
      end
      c.forward_speed = f.object_mode ? '0 : SPEED_W'(speed);
      c.turn_rate     = TURN_W'(turn);
      c.mean_depth    = MEAN_W'(mean);
      c.valid_points  = CNT_W'(count);
      return c;
    endfunction

    function void note_frame(frame_t f);
      expected_cmds.push_back(predict_command(f));
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction

    function void report_field(string field, int want_v, int got_v);
      failures++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want_v, got_v);
    endfunction

    function void check_result(command_t got);
      command_t want;
      results_seen++;
      if (expected_cmds.size() == 0) begin
        failures++;
        $display("%0t: unexpected command, expected none actual speed %0d turn %0d",
                 $time, got.forward_speed, got.turn_rate);
        return;
      end
      want = expected_cmds.pop_front();
      if (got.forward_speed !== want.forward_speed)
        report_field("forward_speed", want.forward_speed, got.forward_speed);
      if (got.turn_rate !== want.turn_rate)
        report_field("turn_rate", want.turn_rate, got.turn_rate);
      if (got.mean_depth !== want.mean_depth)
        report_field("mean_depth", want.mean_depth, got.mean_depth);
      if (got.valid_points !== want.valid_points)
        report_field("valid_points", want.valid_points, got.valid_points);
      if (got.finished !== want.finished)
        report_field("finished", want.finished, got.finished);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fts_in_if  in_ch ();
  fts_out_if out_ch ();

  speed_law_scoreboard cmd_board;
  int                  frames_sent;

  follow_target_speed_law u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // register writes: back to back, enable dropped only after the last one
  // ---------------------------------------------------------------------------
  task automatic write_reg(fts_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cmd_board.set_reg(idx, data);
  endtask

  task automatic apply_settings(reg_set_t s);
    write_reg(fts_pkg::REG_MIN_DEPTH,   s.min_depth);
    write_reg(fts_pkg::REG_MAX_DEPTH,   s.max_depth);
    write_reg(fts_pkg::REG_LEFT_OUTER,  CFG_DATA_W'(s.left_outer));
    write_reg(fts_pkg::REG_LEFT_INNER,  CFG_DATA_W'(s.left_inner));
    write_reg(fts_pkg::REG_RIGHT_INNER, CFG_DATA_W'(s.right_inner));
    write_reg(fts_pkg::REG_RIGHT_OUTER, CFG_DATA_W'(s.right_outer));
    write_reg(fts_pkg::REG_STOP_LIMIT,  CFG_DATA_W'(s.stop_limit));
    cfg_we <= 1'b0;
  endtask

  // random register setting: mostly ordered window and edges, sometimes crossed
  function automatic reg_set_t random_settings();
    reg_set_t s;
    int e[4];
    int a;
    int b;
    a = $urandom_range(65535);
    b = $urandom_range(65535);
    if ($urandom_range(3) != 0) begin
      s.min_depth = (a < b) ? a : b;
      s.max_depth = (a < b) ? b : a;
    end else begin
      s.min_depth = a;
      s.max_depth = b;
    end
    foreach (e[k]) e[k] = $urandom_range(4095);
    if ($urandom_range(3) != 0) e.sort();
    s.left_outer  = e[0];
    s.left_inner  = e[1];
    s.right_inner = e[2];
    s.right_outer = e[3];
    s.stop_limit  = $urandom_range(1) ? $urandom_range(8) : $urandom_range(255);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // frame generation
  // ---------------------------------------------------------------------------
  function automatic frame_t frame_of(int a, int b, int c, int d, int e,
                                      int left, int span, bit om);
    frame_t f;
    f.depth[0]    = a;
    f.depth[1]    = b;
    f.depth[2]    = c;
    f.depth[3]    = d;
    f.depth[4]    = e;
    f.box_left    = left;
    f.box_span    = span;
    f.object_mode = om;
    return f;
  endfunction

  // depth sample: inside the window, on its bounds, at the rails, or anything
  function automatic logic [DEPTH_BITS-1:0] pick_depth();
    int r;
    int lo;
    int hi;
    int near[6];
    r  = $urandom_range(99);
    lo = int'(cmd_board.min_depth) + 1;
    hi = int'(cmd_board.max_depth) - 1;
    if (r < 50 && lo <= hi) return DEPTH_BITS'($urandom_range(hi, lo));
    if (r < 65) begin
      near = '{lo - 2, lo - 1, lo, hi, hi + 1, hi + 2};
      return DEPTH_BITS'(near[$urandom_range(5)]);
    end
    if (r < 75) return $urandom_range(1) ? '1 : '0;
    return DEPTH_BITS'($urandom());
  endfunction

  // box center: around the band edges most of the time
  function automatic int pick_center();
    int edges[4];
    int r;
    int off;
    edges = '{int'(cmd_board.left_outer), int'(cmd_board.left_inner),
              int'(cmd_board.right_inner), int'(cmd_board.right_outer)};
    r = $urandom_range(99);
    if (r < 45) begin
      off = int'($urandom_range(2)) - 1;
      return edges[$urandom_range(3)] + off;
    end
    if (r < 55) return $urandom_range(3);
    if (r < 80) begin
      off = int'($urandom_range(40)) - 20;
      return edges[$urandom_range(3)] + off;
    end
    return $urandom_range(6142);
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int cx;
    int span;
    int left;
    foreach (f.depth[i]) f.depth[i] = pick_depth();
    f.object_mode = ($urandom_range(3) == 0);
    if ($urandom_range(99) < 20) begin
      f.box_left = $urandom_range(4095);
      f.box_span = $urandom_range(4095);
      return f;
    end
    cx = pick_center();
    if (cx < 0) cx = 0;
    span = ($urandom_range(99) < 30) ? $urandom_range(15) : $urandom_range(4095);
    left = cx - span / 2;
    // keep the center reachable with 12-bit fields
    if (left < 0 || left > 4095) begin
      if (cx <= 4095) begin
        span = 0;
        left = cx;
      end else begin
        span = 4095;
        left = cx - 2047;
      end
    end
    f.box_left = left;
    f.box_span = span;
    return f;
  endfunction

  // frame meant to keep the zero-speed run going: no valid depth, center on a
  // band edge or between the inner edges, where the turn law gives zero
  function automatic frame_t idle_frame();
    frame_t f;
    int cands[5];
    int cx;
    int k;
    cands = '{int'(cmd_board.left_outer), int'(cmd_board.left_inner),
              int'(cmd_board.right_inner), int'(cmd_board.right_outer),
              (int'(cmd_board.left_inner) + int'(cmd_board.right_inner)) / 2};
    cx = cands[0];
    for (int t = 0; t < 8; t++) begin
      cx = cands[$urandom_range(4)];
      if (cmd_board.turn_for(cx) == 0) break;
    end
    foreach (f.depth[i]) f.depth[i] = '0;
    // occasional noise that may break the run
    if ($urandom_range(99) < 10) f.depth[$urandom_range(SAMPLE_COUNT - 1)] = pick_depth();
    k = $urandom_range((cx < 100) ? cx : 100);
    f.box_left    = cx - k;
    f.box_span    = 2 * k + $urandom_range(1);
    f.object_mode = $urandom_range(1);
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: random gaps except for a long stretch of back-to-back frames
  // ---------------------------------------------------------------------------
  function automatic bit source_gap();
    if (frames_sent >= 500 && frames_sent < 650) return 1'b0;
    return ($urandom_range(99) < 9);
  endfunction

  // valid stays high from one frame to the next unless a gap is taken
  task automatic push_frame(frame_t f);
    while (source_gap()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.depth_upper_left  <= f.depth[0];
    in_ch.depth_upper_right <= f.depth[1];
    in_ch.depth_lower_left  <= f.depth[2];
    in_ch.depth_lower_right <= f.depth[3];
    in_ch.depth_middle      <= f.depth[4];
    in_ch.box_left          <= f.box_left;
    in_ch.box_span          <= f.box_span;
    in_ch.object_mode       <= f.object_mode;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    cmd_board.note_frame(f);
    frames_sent++;
  endtask

  // drop valid, wait for every expected command, then let the pipeline empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (cmd_board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // directed frames under the reset register values
  task automatic run_directed();
    frame_t plan[$];
    // nothing valid, center in the gap between the inner edges
    plan.push_back(frame_of(0, 0, 0, 0, 0, 640, 0, 0));
    // all samples at the top rail, center at zero
    plan.push_back(frame_of(65535, 65535, 65535, 65535, 65535, 0, 0, 0));
    // samples exactly on the window bounds are rejected, center on the outer left edge
    plan.push_back(frame_of(400, 8000, 400, 8000, 400, 200, 0, 0));
    // samples just inside the bounds
    plan.push_back(frame_of(401, 7999, 0, 0, 0, 199, 0, 0));
    // mean exactly at the speed threshold gives zero speed
    plan.push_back(frame_of(1000, 1000, 1000, 1000, 1000, 201, 0, 0));
    // mean just above the threshold
    plan.push_back(frame_of(1001, 1001, 1001, 1001, 1001, 599, 0, 0));
    // mean rounded down by the integer division
    plan.push_back(frame_of(1001, 1002, 1002, 0, 0, 600, 0, 0));
    // speed reaching the cap exactly
    plan.push_back(frame_of(5000, 5000, 5000, 5000, 5000, 601, 0, 0));
    // object mode zeroes a capped speed
    plan.push_back(frame_of(7999, 7999, 7999, 7999, 7999, 680, 0, 1));
    // just below the cap, right inner band entry
    plan.push_back(frame_of(4999, 4999, 4999, 4999, 4999, 681, 0, 0));
    // a single valid sample
    plan.push_back(frame_of(6000, 0, 0, 0, 0, 1079, 0, 0));
    plan.push_back(frame_of(3000, 3000, 0, 65535, 0, 1080, 0, 0));
    plan.push_back(frame_of(3000, 3000, 3000, 0, 0, 1081, 0, 0));
    // widest box at the far right
    plan.push_back(frame_of(65535, 0, 65535, 0, 65535, 4095, 4095, 0));
    plan.push_back(frame_of(0, 0, 0, 0, 0, 0, 4095, 0));
    // odd span halves down
    plan.push_back(frame_of(2500, 2600, 2700, 2800, 2900, 598, 3, 0));
    plan.push_back(frame_of(43690, 21845, 43690, 21845, 43690, 4095, 0, 1));
    // only the middle sample valid
    plan.push_back(frame_of(0, 0, 0, 0, 2000, 640, 1, 0));
    plan.push_back(frame_of(0, 0, 0, 0, 0, 640, 0, 1));
    foreach (plan[i]) push_frame(plan[i]);
    settle();
  endtask

  // random phase: well-formed zero-speed runs mixed with random frames
  task automatic run_phase(int n_items);
    int sent;
    int burst;
    int top;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        top   = int'(cmd_board.stop_limit) + 3;
        if (top > 40) top = 40;
        burst = $urandom_range(top, 1);
        repeat (burst) push_frame(idle_frame());
        sent += burst;
      end else begin
        push_frame(random_frame());
        sent++;
      end
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, one long hold-off, and a stall-free stretch
  // ---------------------------------------------------------------------------
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!hold_done && cmd_board.results_seen >= 300) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (cmd_board.results_seen >= 500 && cmd_board.results_seen < 650) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 9);
      end
    end
  end

  // result monitor: every accepted transaction goes to the scoreboard
  initial begin
    command_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.forward_speed = out_ch.forward_speed;
        got.turn_rate     = out_ch.turn_rate;
        got.mean_depth    = out_ch.mean_depth;
        got.valid_points  = out_ch.valid_points;
        got.finished      = out_ch.finished;
        cmd_board.check_result(got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    reg_set_t s;
    cmd_board   = new();
    frames_sent = 0;
    rst_n                   <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_index               <= '0;
    cfg_wdata               <= '0;
    in_ch.valid             <= 1'b0;
    in_ch.depth_upper_left  <= '0;
    in_ch.depth_upper_right <= '0;
    in_ch.depth_lower_left  <= '0;
    in_ch.depth_lower_right <= '0;
    in_ch.depth_middle      <= '0;
    in_ch.box_left          <= '0;
    in_ch.box_span          <= '0;
    in_ch.object_mode       <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // reset values written back explicitly
    s = '{400, 8000, 200, 600, 680, 1080, 20};
    apply_settings(s);
    run_phase(147);

    // widest window, all edges at the top, finish on every zero transaction
    s = '{0, 65535, 4095, 4095, 4095, 4095, 0};
    apply_settings(s);
    run_phase(147);

    // empty window, right band over nearly the whole range so it saturates both ways, never finish
    s = '{65535, 0, 0, 0, 0, 4095, 255};
    apply_settings(s);
    run_phase(147);

    // one-value window, wide left band saturating low
    s = '{999, 1001, 0, 4095, 4095, 0, 1};
    apply_settings(s);
    run_phase(147);

    repeat (3) begin
      apply_settings(random_settings());
      run_phase(147);
    end

    if (cmd_board.failures == 0 && cmd_board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
